// ----- design/msr_pkg.sv -----
// Package for the modular square root block: constants, item structs and sequencer states.
// No dependencies; imported by modular_square_root.
package msr_pkg;

    localparam int OPERAND_BITS = 32;
    localparam int NONRES_LIMIT = 256;
    localparam int MOD_W        = 31;
    localparam int ROOT_W       = 30;
    localparam int MUL_A_W      = 32;
    localparam int MUL_STEPS    = MUL_A_W;
    localparam int CNT_W        = 5;
    localparam int Z_W          = 9;

    typedef struct packed {
        logic [MOD_W-1:0]               modulus;
        logic signed [OPERAND_BITS-1:0] value;
    } in_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              found;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_PW_TEST,
        ST_PW_GOTR,
        ST_PW_GOTB,
        ST_C3,
        ST_A1,
        ST_A2,
        ST_A3,
        ST_A4,
        ST_A5,
        ST_A6,
        ST_TQ,
        ST_Z,
        ST_Z2,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_TL,
        ST_TI,
        ST_TB,
        ST_TB2,
        ST_TR,
        ST_TC,
        ST_TT,
        ST_CHK,
        ST_CHK2,
        ST_OUT
    } state_t;

endpackage

// ----- design/modular_square_root.sv -----
// Modular square root top level: sequencer around one bit-serial modular multiplier.
// Depends on msr_pkg for the item structs, constants and state enum.
//
//  channel  ports                        dir  payload
//  input    s_valid s_ready s_data       in   in_t  {modulus, value}
//  result   m_valid m_ready m_data       out  out_t {root, found}
//
// Every modular product runs through the shared multiplier, one bit of
// the multiplicand per cycle; reducing the value takes one such pass too.
// An item's run time depends on its case: trivial moduli skip the multiplier,
// and p = 1 mod 8 is the slowest case, as it adds a non-residue search.
// s_ready is high only in idle; a result waits in its register until taken.
// Reset is synchronous, active low, and returns the sequencer to idle.
module modular_square_root
    import msr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    state_t state_reg, state_next;
    state_t mul_ret_reg, mul_ret_next;
    state_t pw_ret_reg, pw_ret_next;

    logic [MOD_W-1:0]   p_reg, p_next;
    logic [MOD_W-1:0]   d_reg, d_next;
    logic               neg_reg, neg_next;
    logic [MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [MOD_W-1:0]   mul_b_reg, mul_b_next;
    logic [MOD_W-1:0]   mul_r_reg, mul_r_next;
    logic [CNT_W-1:0]   mul_cnt_reg, mul_cnt_next;
    logic [MOD_W-1:0]   pw_r_reg, pw_r_next;
    logic [MOD_W-1:0]   pw_b_reg, pw_b_next;
    logic [MOD_W-1:0]   pw_e_reg, pw_e_next;
    logic [MOD_W-1:0]   ra_reg, ra_next;
    logic [MOD_W-1:0]   rb_reg, rb_next;
    logic [MOD_W-1:0]   rc_reg, rc_next;
    logic [MOD_W-1:0]   rr_reg, rr_next;
    logic [MOD_W-1:0]   rt_reg, rt_next;
    logic [MOD_W-1:0]   rq_reg, rq_next;
    logic [CNT_W-1:0]   m_reg, m_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [Z_W-1:0]     z_reg, z_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic               found_reg, found_next;

    logic [MUL_A_W-1:0] raw;
    logic [MUL_A_W-1:0] mag;
    logic [MUL_A_W-1:0] dbl, dbl_red, sum, sum_red, p_ext;
    logic [MOD_W-1:0]   red_d;
    logic [MUL_A_W-1:0] p_plus;
    logic [MUL_A_W-1:0] q_plus;
    logic [MOD_W-1:0]   half_p;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = '{root: root_reg, found: found_reg};

    assign raw = MUL_A_W'(s_data.value);
    assign mag = raw[OPERAND_BITS-1] ? (~raw + MUL_A_W'(1)) : raw;

    // One multiplier step: double and reduce, then add the multiplier and reduce.
    assign p_ext   = {1'b0, p_reg};
    assign dbl     = {mul_r_reg, 1'b0};
    assign dbl_red = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
    assign sum     = dbl_red + (mul_a_reg[MUL_A_W-1] ? {1'b0, mul_b_reg} : '0);
    assign sum_red = (sum >= p_ext) ? (sum - p_ext) : sum;

    assign red_d  = (neg_reg && mul_r_reg != '0) ? (p_reg - mul_r_reg)
                  : (neg_reg ? '0 : mul_r_reg);
    assign p_plus = p_ext + MUL_A_W'(1);
    assign q_plus = {1'b0, rq_reg} + MUL_A_W'(1);
    assign half_p = p_reg >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mul_ret_reg <= mul_ret_next;
        pw_ret_reg  <= pw_ret_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        neg_reg     <= neg_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_r_reg   <= mul_r_next;
        mul_cnt_reg <= mul_cnt_next;
        pw_r_reg    <= pw_r_next;
        pw_b_reg    <= pw_b_next;
        pw_e_reg    <= pw_e_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        rc_reg      <= rc_next;
        rr_reg      <= rr_next;
        rt_reg      <= rt_next;
        rq_reg      <= rq_next;
        m_reg       <= m_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        z_reg       <= z_next;
        root_reg    <= root_next;
        found_reg   <= found_next;
    end

    always_comb begin
        state_next   = state_reg;
        mul_ret_next = mul_ret_reg;
        pw_ret_next  = pw_ret_reg;
        p_next       = p_reg;
        d_next       = d_reg;
        neg_next     = neg_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        mul_r_next   = mul_r_reg;
        mul_cnt_next = mul_cnt_reg;
        pw_r_next    = pw_r_reg;
        pw_b_next    = pw_b_reg;
        pw_e_next    = pw_e_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        rc_next      = rc_reg;
        rr_next      = rr_reg;
        rt_next      = rt_reg;
        rq_next      = rq_reg;
        m_next       = m_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        z_next       = z_reg;
        root_next    = root_reg;
        found_next   = found_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_next   = s_data.modulus;
                    neg_next = raw[OPERAND_BITS-1];
                    if (s_data.modulus < MOD_W'(2) ||
                        (!s_data.modulus[0] && s_data.modulus != MOD_W'(2))) begin
                        root_next  = '0;
                        found_next = 1'b0;
                        state_next = ST_OUT;
                    end else if (s_data.modulus == MOD_W'(2)) begin
                        root_next  = ROOT_W'(raw[0]);
                        found_next = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        // reduce the magnitude: mag * 1 mod p
                        mul_a_next   = mag;
                        mul_b_next   = MOD_W'(1);
                        mul_r_next   = '0;
                        mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                        mul_ret_next = ST_RED;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                mul_r_next   = sum_red[MOD_W-1:0];
                mul_a_next   = mul_a_reg << 1;
                mul_cnt_next = mul_cnt_reg - CNT_W'(1);
                if (mul_cnt_reg == '0) begin
                    state_next = mul_ret_reg;
                end
            end
            ST_RED: begin
                d_next = red_d;
                if (red_d < MOD_W'(2)) begin
                    root_next  = ROOT_W'(red_d);
                    found_next = 1'b1;
                    state_next = ST_OUT;
                end else if (p_reg[1:0] == 2'b11) begin
                    pw_r_next   = MOD_W'(1);
                    pw_b_next   = red_d;
                    pw_e_next   = MOD_W'(p_plus >> 2);
                    pw_ret_next = ST_C3;
                    state_next  = ST_PW_TEST;
                end else if (p_reg[2:0] == 3'b101) begin
                    mul_a_next   = MUL_A_W'(2);
                    mul_b_next   = red_d;
                    mul_r_next   = '0;
                    mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                    mul_ret_next = ST_A1;
                    state_next   = ST_MUL;
                end else begin
                    rq_next    = p_reg - MOD_W'(1);
                    m_next     = '0;
                    z_next     = Z_W'(2);
                    state_next = ST_TQ;
                end
            end
            // square-and-multiply; returns to pw_ret_reg with result in pw_r_reg
            ST_PW_TEST: begin
                if (pw_e_reg == '0) begin
                    state_next = pw_ret_reg;
                end else begin
                    mul_a_next   = {1'b0, pw_e_reg[0] ? pw_r_reg : pw_b_reg};
                    mul_b_next   = pw_b_reg;
                    mul_r_next   = '0;
                    mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                    mul_ret_next = pw_e_reg[0] ? ST_PW_GOTR : ST_PW_GOTB;
                    state_next   = ST_MUL;
                end
            end
            ST_PW_GOTR: begin
                pw_r_next    = mul_r_reg;
                mul_a_next   = {1'b0, pw_b_reg};
                mul_b_next   = pw_b_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_PW_GOTB;
                state_next   = ST_MUL;
            end
            ST_PW_GOTB: begin
                pw_b_next  = mul_r_reg;
                pw_e_next  = pw_e_reg >> 1;
                state_next = ST_PW_TEST;
            end
            ST_C3: begin
                rr_next    = pw_r_reg;
                state_next = ST_CHK;
            end
            // Atkin: ra = 2d, rb = v, rc = i - 1
            ST_A1: begin
                ra_next     = mul_r_reg;
                pw_r_next   = MOD_W'(1);
                pw_b_next   = mul_r_reg;
                pw_e_next   = p_reg >> 3;
                pw_ret_next = ST_A2;
                state_next  = ST_PW_TEST;
            end
            ST_A2: begin
                rb_next      = pw_r_reg;
                mul_a_next   = {1'b0, pw_r_reg};
                mul_b_next   = pw_r_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_A3;
                state_next   = ST_MUL;
            end
            ST_A3: begin
                mul_a_next   = {1'b0, ra_reg};
                mul_b_next   = mul_r_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_A4;
                state_next   = ST_MUL;
            end
            ST_A4: begin
                rc_next      = (mul_r_reg == '0) ? (p_reg - MOD_W'(1))
                                                 : (mul_r_reg - MOD_W'(1));
                mul_a_next   = {1'b0, d_reg};
                mul_b_next   = rb_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_A5;
                state_next   = ST_MUL;
            end
            ST_A5: begin
                mul_a_next   = {1'b0, mul_r_reg};
                mul_b_next   = rc_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_A6;
                state_next   = ST_MUL;
            end
            ST_A6: begin
                rr_next    = mul_r_reg;
                state_next = ST_CHK;
            end
            // Tonelli-Shanks: strip factors of two from p - 1
            ST_TQ: begin
                if (!rq_reg[0]) begin
                    rq_next = rq_reg >> 1;
                    m_next  = m_reg + CNT_W'(1);
                end else begin
                    state_next = ST_Z;
                end
            end
            ST_Z: begin
                if ({{(MOD_W-Z_W){1'b0}}, z_reg} < p_reg && z_reg < Z_W'(NONRES_LIMIT)) begin
                    pw_r_next   = MOD_W'(1);
                    pw_b_next   = MOD_W'(z_reg);
                    pw_e_next   = half_p;
                    pw_ret_next = ST_Z2;
                    state_next  = ST_PW_TEST;
                end else begin
                    root_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_Z2: begin
                if (pw_r_reg == p_reg - MOD_W'(1)) begin
                    pw_r_next   = MOD_W'(1);
                    pw_b_next   = MOD_W'(z_reg);
                    pw_e_next   = rq_reg;
                    pw_ret_next = ST_T1;
                    state_next  = ST_PW_TEST;
                end else begin
                    z_next     = z_reg + Z_W'(1);
                    state_next = ST_Z;
                end
            end
            ST_T1: begin
                rc_next     = pw_r_reg;
                pw_r_next   = MOD_W'(1);
                pw_b_next   = d_reg;
                pw_e_next   = MOD_W'(q_plus >> 1);
                pw_ret_next = ST_T2;
                state_next  = ST_PW_TEST;
            end
            ST_T2: begin
                rr_next     = pw_r_reg;
                pw_r_next   = MOD_W'(1);
                pw_b_next   = d_reg;
                pw_e_next   = rq_reg;
                pw_ret_next = ST_T3;
                state_next  = ST_PW_TEST;
            end
            ST_T3: begin
                rt_next    = pw_r_reg;
                state_next = ST_TL;
            end
            ST_TL: begin
                if (rt_reg == MOD_W'(1)) begin
                    state_next = ST_CHK;
                end else begin
                    i_next       = CNT_W'(1);
                    mul_a_next   = {1'b0, rt_reg};
                    mul_b_next   = rt_reg;
                    mul_r_next   = '0;
                    mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                    mul_ret_next = ST_TI;
                    state_next   = ST_MUL;
                end
            end
            // find the least i with t^(2^i) = 1
            ST_TI: begin
                if (i_reg < m_reg && mul_r_reg != MOD_W'(1)) begin
                    i_next       = i_reg + CNT_W'(1);
                    mul_a_next   = {1'b0, mul_r_reg};
                    mul_b_next   = mul_r_reg;
                    mul_r_next   = '0;
                    mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                    mul_ret_next = ST_TI;
                    state_next   = ST_MUL;
                end else if (i_reg >= m_reg) begin
                    root_next  = '0;
                    found_next = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    rb_next    = rc_reg;
                    j_next     = m_reg - i_reg - CNT_W'(1);
                    state_next = ST_TB;
                end
            end
            ST_TB: begin
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                state_next   = ST_MUL;
                if (j_reg == '0) begin
                    mul_a_next   = {1'b0, rr_reg};
                    mul_b_next   = rb_reg;
                    mul_ret_next = ST_TR;
                end else begin
                    j_next       = j_reg - CNT_W'(1);
                    mul_a_next   = {1'b0, rb_reg};
                    mul_b_next   = rb_reg;
                    mul_ret_next = ST_TB2;
                end
            end
            ST_TB2: begin
                rb_next    = mul_r_reg;
                state_next = ST_TB;
            end
            ST_TR: begin
                rr_next      = mul_r_reg;
                mul_a_next   = {1'b0, rb_reg};
                mul_b_next   = rb_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_TC;
                state_next   = ST_MUL;
            end
            ST_TC: begin
                rc_next      = mul_r_reg;
                mul_a_next   = {1'b0, rt_reg};
                mul_b_next   = mul_r_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_TT;
                state_next   = ST_MUL;
            end
            ST_TT: begin
                rt_next    = mul_r_reg;
                m_next     = i_reg;
                state_next = ST_TL;
            end
            // verify the candidate by squaring it
            ST_CHK: begin
                mul_a_next   = {1'b0, rr_reg};
                mul_b_next   = rr_reg;
                mul_r_next   = '0;
                mul_cnt_next = CNT_W'(MUL_STEPS - 1);
                mul_ret_next = ST_CHK2;
                state_next   = ST_MUL;
            end
            ST_CHK2: begin
                if (mul_r_reg == d_reg) begin
                    found_next = 1'b1;
                    root_next  = (rr_reg > half_p) ? ROOT_W'(p_reg - rr_reg)
                                                   : ROOT_W'(rr_reg);
                end else begin
                    found_next = 1'b0;
                    root_next  = '0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- dv/modular_square_root_tb.sv -----
// Self-checking testbench for modular_square_root: a queue-fed driver, a stalling receiver
// and a predictor of the smaller root mod p. Depends on msr_pkg and the modular_square_root RTL.
module modular_square_root_tb;
    import msr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_ITEMS = 126;
    localparam int  LONG_HOLD    = 3000;
    localparam longint CYCLE_LIMIT = 6000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    in_t  pending_items[$];
    bit   drain_before[$];
    out_t expected_roots[$];

    int     mismatches;
    int     burst_left;
    int     gap_left;
    int     rx_count;
    int     hold_left;
    int     rx_mode;
    int     rx_mode_left;
    bit     held_once;
    bit     stim_done;
    longint cycle_count;

    modular_square_root i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                                longint unsigned p);
        return (a * b) % p;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                                longint unsigned p);
        longint unsigned acc;
        longint unsigned b;
        acc = 1 % p;
        b = base % p;
        while (e != 0) begin
            if (e[0])
                acc = mul_mod(acc, b, p);
            b = mul_mod(b, b, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Tonelli-Shanks for p = 1 mod 8; returns 0 when no candidate exists.
    function automatic bit shanks_root(longint unsigned p, longint unsigned d,
                                       output longint unsigned cand);
        longint unsigned q, s, z, c, r, t, m, i, tt, b;
        bit have;
        q = p - 1;
        s = 0;
        have = 0;
        cand = 0;
        while (q[0] == 1'b0) begin
            q = q >> 1;
            s++;
        end
        for (z = 2; z < p && z < NONRES_LIMIT; z++) begin
            if (pow_mod(z, (p - 1) / 2, p) == p - 1) begin
                have = 1;
                break;
            end
        end
        if (!have)
            return 0;
        c = pow_mod(z, q, p);
        r = pow_mod(d, (q + 1) / 2, p);
        t = pow_mod(d, q, p);
        m = s;
        while (t != 1) begin
            i = 1;
            tt = mul_mod(t, t, p);
            while (i < m && tt != 1) begin
                tt = mul_mod(tt, tt, p);
                i++;
            end
            if (i >= m)
                return 0;
            b = c;
            for (longint unsigned j = 0; j < m - i - 1; j++)
                b = mul_mod(b, b, p);
            r = mul_mod(r, b, p);
            c = mul_mod(b, b, p);
            t = mul_mod(t, c, p);
            m = i;
        end
        cand = r;
        return 1;
    endfunction

    function automatic out_t predict_root(in_t it);
        longint unsigned p, d, mag, root, d2, v, iv;
        logic [OPERAND_BITS-1:0] raw, neg;
        bit ok;
        out_t res;
        p = it.modulus;
        raw = it.value;
        neg = -raw;
        root = 0;
        ok = 0;
        if (p >= 2) begin
            if (raw[OPERAND_BITS-1]) begin
                mag = longint'(neg) % p;
                d = (mag == 0) ? 0 : p - mag;
            end else begin
                d = longint'(raw) % p;
            end
            if (p == 2) begin
                root = d;
                ok = 1;
            end else if (p[0] == 1'b0) begin
                ok = 0;
            end else if (d == 0 || d == 1) begin
                root = d;
                ok = 1;
            end else begin
                if (p % 4 == 3) begin
                    root = pow_mod(d, (p + 1) / 4, p);
                    ok = 1;
                end else if (p % 8 == 5) begin
                    d2 = mul_mod(2, d, p);
                    v = pow_mod(d2, (p - 5) / 8, p);
                    iv = mul_mod(d2, mul_mod(v, v, p), p);
                    root = mul_mod(mul_mod(d, v, p), (iv + p - 1) % p, p);
                    ok = 1;
                end else begin
                    ok = shanks_root(p, d, root);
                end
                if (ok) begin
                    root = root % p;
                    ok = (mul_mod(root, root, p) == d);
                end
            end
            if (ok && root > p / 2)
                root = p - root;
        end
        if (!ok)
            root = 0;
        res.root = root[ROOT_W-1:0];
        res.found = ok;
        return res;
    endfunction

    function automatic in_t make_item(longint unsigned p, longint signed v);
        in_t it;
        it.modulus = p[MOD_W-1:0];
        it.value = v[OPERAND_BITS-1:0];
        return it;
    endfunction

    // Mostly known primes, some small odd or even moduli, a few large non 1 mod 8 ones.
    function automatic longint unsigned pick_modulus();
        longint unsigned primes[16] = '{3, 5, 7, 11, 13, 17, 41, 73, 97, 113, 193, 257,
                                        65537, 998244353, 1000000009, 2147483647};
        longint unsigned p;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return primes[$urandom_range(0, 15)];
        if (sel < 85)
            return $urandom_range(0, 300);
        p = {$urandom} & 32'h7FFF_FFFF;
        // keep large random moduli off the slow non-residue search
        if (p % 8 == 1)
            p = p ^ 2;
        return p;
    endfunction

    initial begin
        longint unsigned p, r;
        int sel;
        mismatches = 0;
        stim_done = 0;

        pending_items.push_back(make_item(0, 5));
        pending_items.push_back(make_item(1, -7));
        pending_items.push_back(make_item(2, 3));
        pending_items.push_back(make_item(2, -4));
        pending_items.push_back(make_item(2, -1));
        pending_items.push_back(make_item(4, 1));
        pending_items.push_back(make_item(2147483646, 9));
        pending_items.push_back(make_item(7, 14));
        pending_items.push_back(make_item(7, 1));
        pending_items.push_back(make_item(7, -1));
        pending_items.push_back(make_item(7, 2));
        pending_items.push_back(make_item(13, 10));
        pending_items.push_back(make_item(13, 5));
        pending_items.push_back(make_item(17, 2));
        pending_items.push_back(make_item(17, 3));
        pending_items.push_back(make_item(9, 4));
        pending_items.push_back(make_item(15, 4));
        pending_items.push_back(make_item(21, 4));
        pending_items.push_back(make_item(2147483647, -2147483648));
        pending_items.push_back(make_item(2147483647, 2147483647));
        pending_items.push_back(make_item(2147483629, 4));
        pending_items.push_back(make_item(2013265921, -2));
        pending_items.push_back(make_item(998244353, 3));
        pending_items.push_back(make_item(1000000009, 16));
        for (int k = 0; k < pending_items.size(); k++)
            drain_before.push_back(0);
        drain_before[10] = 1;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            p = pick_modulus();
            sel = $urandom_range(0, 99);
            if (p >= 2 && sel < 55) begin
                r = $urandom % p;
                r = mul_mod(r, r, p);
                if (sel < 30)
                    pending_items.push_back(make_item(p, longint'(r)));
                else
                    pending_items.push_back(make_item(p, longint'(r) - longint'(p)));
            end else begin
                pending_items.push_back(make_item(p, longint'(signed'($urandom))));
            end
            drain_before.push_back(k == 90);
        end
        stim_done = 1;
    end

    // Driver: bursts of items separated by random gaps.
    always @(posedge aclk) begin
        bit accepted;
        bit may_send;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            accepted = s_valid && s_ready;
            if (accepted)
                expected_roots.push_back(predict_root(s_data));
            if (s_valid && !accepted) begin
                // hold the item until it is taken
            end else if (accepted && burst_left == 0) begin
                s_valid <= 1'b0;
                gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200)
                                                       : $urandom_range(0, 12);
                burst_left <= $urandom_range(1, 8);
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                may_send = pending_items.size() > 0;
                if (may_send && drain_before[0] && (accepted || expected_roots.size() != 0))
                    may_send = 0;
                if (may_send) begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    void'(drain_before.pop_front());
                    if (accepted)
                        burst_left <= burst_left - 1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: its own stall pattern plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_count <= 0;
            hold_left <= 0;
            held_once <= 0;
            rx_mode <= 0;
            rx_mode_left <= 0;
        end else begin
            if (m_valid && m_ready)
                rx_count <= rx_count + 1;
            if (!held_once && rx_count == 30) begin
                held_once <= 1;
                hold_left <= LONG_HOLD;
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode <= $urandom_range(0, 2);
                    rx_mode_left <= $urandom_range(50, 3000);
                end else begin
                    rx_mode_left <= rx_mode_left - 1;
                end
                case (rx_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 5) == 0);
                    end
                endcase
            end
        end
    end

    // Monitor: compare each result with the oldest expected root.
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result root=%0d found=%0d", m_data.root,
                             m_data.found);
            end else begin
                want = expected_roots.pop_front();
                if (m_data.root !== want.root || m_data.found !== want.found) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected root=%0d found=%0d, got root=%0d found=%0d",
                                 want.root, want.found, m_data.root, m_data.found);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("modular_square_root_tb failed");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_roots.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("modular_square_root_tb passed");
        else
            $display("modular_square_root_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/msr_pkg.sv
design/modular_square_root.sv
dv/modular_square_root_tb.sv
